// ===== rtl/pttt_pkg.sv =====
// shared types, codes and sizes for the periodic task timer table
package pttt_pkg;

  localparam int SLOTS_DEF = 8;
  localparam int MAX_FIRES = 8;
  localparam int QDEPTH    = 2;
  localparam int FCW       = $clog2(MAX_FIRES + 1);

  localparam logic [2:0] KIND_TICK   = 3'd0;
  localparam logic [2:0] KIND_SETUP  = 3'd1;
  localparam logic [2:0] KIND_START  = 3'd2;
  localparam logic [2:0] KIND_STOP   = 3'd3;
  localparam logic [2:0] KIND_DELETE = 3'd4;

  localparam logic [1:0] EV_FIRE = 2'd0;
  localparam logic [1:0] EV_DONE = 2'd1;
  localparam logic [1:0] EV_MISS = 2'd2;
  localparam logic [1:0] EV_BAD  = 2'd3;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_SETUP,
    OP_START,
    OP_STOP,
    OP_DELETE,
    OP_BAD
  } op_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  handle;
    logic [15:0] period;
    logic [7:0]  repeat_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic [7:0] fired_handle;
    logic [2:0] slot_index;
    logic       last;
  } out_item_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  handle;
    logic [15:0] period;
    logic [7:0]  repeat_count;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  handle;
    logic [16:0] counter;
    logic [15:0] period;
    logic [7:0]  remaining;
  } slot_t;

  localparam slot_t SLOT_RESET = '{handle: 8'd0, counter: 17'd1, period: 16'd0,
                                   remaining: 8'd0};

endpackage

// ===== rtl/pttt_ram.sv =====
// generic single write port ram with registered read
module pttt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== rtl/pttt_front.sv =====
// front end: accepts items, decodes the kind and screens bad handles
module pttt_front (
  input  logic               in_valid,
  input  pttt_pkg::in_item_t in_item,
  output logic               in_stall,
  input  logic               q_full,
  output logic               push,
  output pttt_pkg::cmd_t     push_cmd
);
  import pttt_pkg::*;

  logic drop;
  op_t  op;

  always_comb begin
    drop = 1'b0;
    op   = OP_TICK;
    unique case (in_item.kind)
      KIND_TICK:   op = OP_TICK;
      KIND_SETUP:  op = OP_SETUP;
      KIND_START:  op = OP_START;
      KIND_STOP:   op = OP_STOP;
      KIND_DELETE: op = OP_DELETE;
      default:     drop = 1'b1;
    endcase
    // handle zero is reserved for every slot operation
    if (!drop && op != OP_TICK && in_item.handle == 8'd0) begin
      op = OP_BAD;
    end
  end

  assign in_stall              = q_full;
  assign push                  = in_valid && !q_full && !drop;
  assign push_cmd.op           = op;
  assign push_cmd.handle       = in_item.handle;
  assign push_cmd.period       = in_item.period;
  assign push_cmd.repeat_count = in_item.repeat_count;

endmodule

// ===== rtl/pttt_queue.sv =====
// short command queue between the front end and the slot walker
module pttt_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pttt_pkg::cmd_t push_cmd,
  output logic           full,
  output logic           q_valid,
  output pttt_pkg::cmd_t q_cmd,
  input  logic           pop
);
  import pttt_pkg::*;

  localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  cmd_t          mem_r [QDEPTH];
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;

  assign full    = cnt_r == (AW + 1)'(QDEPTH);
  assign q_valid = cnt_r != '0;
  assign q_cmd   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = wp_r + AW'(1);
    end
    if (pop) begin
      rp_nxt = rp_r + AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + (AW + 1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/pttt_back.sv =====
// back end: walks the slot table one slot per cycle while the output is free and issues results
module pttt_back #(
  parameter int SLOTS = pttt_pkg::SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  pttt_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output pttt_pkg::out_item_t out_item
);
  import pttt_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS - 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WALK  = 4'b0010,
    S_FLUSH = 4'b0100,
    S_REPLY = 4'b1000
  } state_t;

  state_t    state_r, state_nxt;
  cmd_t      cmd_r, cmd_nxt;
  logic [SW-1:0] idx_r, idx_nxt, idx_inc;
  logic [FCW-1:0] fire_cnt_r, fire_cnt_nxt;
  logic      pend_v_r, pend_v_nxt;
  out_item_t pend_r, pend_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;
  logic [SLOTS-1:0] used_r, used_nxt;
  logic [SLOTS-1:0] init_r, init_nxt;

  logic [SW-1:0]           rd_addr;
  logic [$bits(slot_t)-1:0] rd_data;
  logic                    we;
  slot_t                   wr_slot;

  logic      out_free, is_last, push;
  out_item_t push_item;
  slot_t     d, tick_wr, op_wr;
  logic [16:0] cnt_inc;
  logic [7:0]  rem_dec;
  logic      active, fire, used, match, take, op_used;

  pttt_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (we),
    .waddr (idx_r),
    .wdata (wr_slot),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // slot arithmetic on the entry whose read data is present
  always_comb begin
    d       = init_r[idx_r] ? slot_t'(rd_data) : SLOT_RESET;
    is_last = idx_r == LAST_IDX;
    idx_inc = is_last ? '0 : idx_r + SW'(1);

    active  = d.period != 16'd0;
    cnt_inc = (d.counter <= {1'b0, d.period}) ? d.counter + 17'd1 : d.counter;
    rem_dec = d.remaining - 8'd1;
    fire    = active && (fire_cnt_r < FCW'(MAX_FIRES)) && (cnt_inc > {1'b0, d.period});
    tick_wr = d;
    if (fire) begin
      tick_wr.counter = 17'd1;
      if (d.remaining != 8'd0) begin
        tick_wr.remaining = rem_dec;
        if (rem_dec == 8'd0) begin
          tick_wr.period = 16'd0;
        end
      end
    end else begin
      tick_wr.counter = cnt_inc;
    end

    used  = used_r[idx_r];
    match = used && d.handle == cmd_r.handle;
    op_wr   = d;
    op_used = used;
    take    = 1'b0;
    unique case (cmd_r.op) inside
      OP_SETUP, OP_START: begin
        take = (cmd_r.op == OP_START) ? (match || !used) : !used;
        op_wr.handle    = cmd_r.handle;
        op_wr.period    = cmd_r.period;
        op_wr.remaining = cmd_r.repeat_count;
        op_used         = 1'b1;
      end
      OP_STOP, OP_DELETE: begin
        take = match;
        op_wr.counter   = 17'd1;
        op_wr.period    = 16'd0;
        op_wr.remaining = 8'd0;
        if (cmd_r.op == OP_DELETE) begin
          op_wr.handle = 8'd0;
          op_used      = 1'b0;
        end
      end
      default: take = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    idx_nxt      = idx_r;
    fire_cnt_nxt = fire_cnt_r;
    pend_v_nxt   = pend_v_r;
    pend_nxt     = pend_r;
    used_nxt     = used_r;
    init_nxt     = init_r;
    out_free     = !out_valid_r || !out_stall;
    q_pop        = 1'b0;
    rd_addr      = idx_r;
    we           = 1'b0;
    wr_slot      = tick_wr;
    push         = 1'b0;
    push_item    = pend_r;

    unique case (state_r)
      S_IDLE: begin
        rd_addr = '0;
        if (q_valid) begin
          q_pop        = 1'b1;
          cmd_nxt      = q_cmd;
          idx_nxt      = '0;
          fire_cnt_nxt = '0;
          pend_v_nxt   = 1'b0;
          state_nxt    = (q_cmd.op == OP_BAD) ? S_REPLY : S_WALK;
        end
      end
      S_WALK: begin
        // hold on the same slot while the output register is blocked
        if (out_free) begin
          rd_addr = idx_inc;
          idx_nxt = idx_inc;
          if (cmd_r.op == OP_TICK) begin
            we      = active;
            wr_slot = tick_wr;
            if (fire) begin
              fire_cnt_nxt = fire_cnt_r + FCW'(1);
              pend_nxt     = '{event_res: EV_FIRE, fired_handle: d.handle,
                               slot_index: 3'(idx_r), last: 1'b0};
              pend_v_nxt   = 1'b1;
              push         = pend_v_r;
              push_item    = pend_r;
            end
            if (is_last) begin
              state_nxt = (pend_v_r || fire) ? S_FLUSH : S_IDLE;
            end
          end else if (take) begin
            we             = 1'b1;
            wr_slot        = op_wr;
            used_nxt[idx_r] = op_used;
            push           = 1'b1;
            push_item      = '{event_res: EV_DONE, fired_handle: cmd_r.handle,
                               slot_index: 3'(idx_r), last: 1'b1};
            state_nxt      = S_IDLE;
          end else if (is_last) begin
            push      = 1'b1;
            push_item = '{event_res: EV_MISS, fired_handle: 8'd0, slot_index: 3'd0,
                          last: 1'b1};
            state_nxt = S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          push           = 1'b1;
          push_item      = pend_r;
          push_item.last = 1'b1;
          pend_v_nxt     = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      S_REPLY: begin
        if (out_free) begin
          push      = 1'b1;
          push_item = '{event_res: EV_BAD, fired_handle: 8'd0, slot_index: 3'd0,
                        last: 1'b1};
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (we) begin
      init_nxt[idx_r] = 1'b1;
    end

    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_nxt       = push_item;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      fire_cnt_r  <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      used_r      <= '0;
      init_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      fire_cnt_r  <= fire_cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      used_r      <= used_nxt;
      init_r      <= init_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r == S_WALK && out_free))
    else $error("slot write outside the walk");

  a_fire_limit: assert property (@(posedge clk) disable iff (!rst_n)
    fire_cnt_r <= FCW'(MAX_FIRES))
    else $error("too many fires in one tick");

  a_pend_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_v_r && state_r != S_IDLE) |-> cmd_r.op == OP_TICK)
    else $error("pending fire outside a tick");

  a_flush_pend: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FLUSH |-> pend_v_r)
    else $error("flush without a pending fire");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_item.event_res != EV_FIRE) |-> push_item.last)
    else $error("status item without last");

endmodule

// ===== rtl/periodic_task_timer_table.sv =====
// periodic task timer table: front end, command queue and slot walker
// a command leaves the queue for the walker, which takes one slot per cycle through the
// single read port of the slot ram while the output register is free; a tick walks every
// slot and then flushes when any slot fired, an operation stops at its slot, a bad handle
// goes to the reply state, and a blocked output register holds the walk on its current slot
// reset is synchronous; slot ram is not swept, an entry never written reads as a free
// stopped slot with counter 1
module periodic_task_timer_table #(
  parameter int SLOTS = pttt_pkg::SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pttt_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output pttt_pkg::out_item_t out_item
);
  import pttt_pkg::*;

  logic q_full, push, q_valid, q_pop;
  cmd_t push_cmd, q_cmd;

  pttt_front u_front (
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_stall (in_stall),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  pttt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (q_pop)
  );

  pttt_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
